FILE: rtl/uniform_grid_linear_interpolator_defines.svh
// assertion macros for the uniform grid interpolator checker
// no dependencies
`ifndef UNIFORM_GRID_LINEAR_INTERPOLATOR_DEFINES_SVH
`define UNIFORM_GRID_LINEAR_INTERPOLATOR_DEFINES_SVH

// clocked assertion, off while reset is held
`define UGLI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// a condition that must never hold
`define UGLI_NEVER(label, clk, rst_n, cond, msg) \
  `UGLI_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: rtl/ugli_pkg.sv
// types and codes shared by the uniform grid interpolator
// no dependencies
package ugli_pkg;

  localparam logic [1:0] OP_EVAL  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] CFG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] CFG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] CFG_NODES      = 2'd2;

  localparam logic [8:0] NODES_RESET = 9'd256;
  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] x_value;
    logic [7:0]         node_index;
    logic signed [31:0] node_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               in_range;
  } out_item_t;

  // control and payload that travel along the pipeline
  typedef struct packed {
    logic               valid;
    logic [1:0]         op;
    logic               ok;
    logic [7:0]         idx;
    logic signed [31:0] val;
  } meta_t;

endpackage

FILE: rtl/ugli_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ugli_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: rtl/ugli_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on ugli_pkg
module ugli_div import ugli_pkg::*; #(
  parameter int QW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  meta_t         in_meta,
  input  logic [31:0]   in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [31:0]   in_span,
  output meta_t         out_meta,
  output logic [QW-1:0] out_quot
);
  meta_t         meta_r [1:QW];
  logic [31:0]   rem_r  [1:QW];
  logic [QW-1:0] low_r  [1:QW];
  logic [31:0]   span_r [1:QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    meta_t         cm;
    logic [31:0]   cr;
    logic [QW-1:0] cl;
    logic [31:0]   cs;
    logic [32:0]   t;
    logic          ge;
    logic [32:0]   diff;
    logic [QW-1:0] low_nxt;

    if (g == 0) begin : g_first
      assign cm = in_meta;
      assign cr = in_rem;
      assign cl = in_low;
      assign cs = in_span;
    end else begin : g_rest
      assign cm = meta_r[g];
      assign cr = rem_r[g];
      assign cl = low_r[g];
      assign cs = span_r[g];
    end

    // shift in the next numerator bit and try a subtract
    assign t    = {cr, cl[QW-1]};
    assign diff = t - {1'b0, cs};
    assign ge   = (t >= {1'b0, cs});
    if (QW > 1) begin : g_shift
      assign low_nxt = {cl[QW-2:0], ge};
    end else begin : g_one
      assign low_nxt = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        meta_r[g+1].valid <= 1'b0;
      end else begin
        meta_r[g+1] <= cm;
      end
      rem_r[g+1]  <= ge ? diff[31:0] : t[31:0];
      low_r[g+1]  <= low_nxt;
      span_r[g+1] <= cs;
    end
  end

  assign out_meta = meta_r[QW];
  assign out_quot = low_r[QW];
endmodule

FILE: rtl/uniform_grid_linear_interpolator.sv
// Piecewise linear interpolator over a uniform node table. One command is taken
// every cycle (busy is always low) and its single result appears on out_valid
// in order; writes, reads and evaluates all pass through the same pipeline.
// The divider yields one quotient bit per pipeline stage for the bin and its
// 16 bit fraction.
// Results cannot be held off: each one is on the out ports for a single cycle.
// Configuration writes apply to commands taken afterwards.
// depends on ugli_pkg, ugli_div, ugli_ram
module uniform_grid_linear_interpolator import ugli_pkg::*; #(
  parameter int NODE_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  output out_item_t   out_data
);
  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int QW = AW + FRAC_BITS;
  localparam int CW = $clog2(NODE_COUNT + 1);
  localparam int KW = (CW > 9) ? CW : 9;
  localparam int XW = (AW > 8) ? AW : 8;
  localparam int PW = 32 + AW;

  logic signed [31:0] range_low_r, range_high_r;
  logic [8:0]         nodes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= '0;
      nodes_r      <= NODES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        CFG_RANGE_HIGH: range_high_r <= cfg_data;
        CFG_NODES:      nodes_r      <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: decode, range checks, offset and span
  logic [KW-1:0] n_raw, n_eff;
  logic [KW-1:0] idx_k;
  logic [32:0]   d_full, span_full;
  logic          x_in, idx_in;
  meta_t         m1_nxt;

  always_comb begin
    n_raw = KW'(nodes_r);
    if (n_raw < KW'(2)) begin
      n_eff = KW'(2);
    end else if (n_raw > KW'(NODE_COUNT)) begin
      n_eff = KW'(NODE_COUNT);
    end else begin
      n_eff = n_raw;
    end
    idx_k     = KW'(in_data.node_index);
    idx_in    = idx_k < n_eff;
    x_in      = (in_data.x_value > range_low_r) && (in_data.x_value < range_high_r);
    d_full    = {in_data.x_value[31], in_data.x_value} - {range_low_r[31], range_low_r};
    span_full = {range_high_r[31], range_high_r} - {range_low_r[31], range_low_r};
    m1_nxt.valid = start;
    m1_nxt.op    = in_data.opcode;
    m1_nxt.idx   = in_data.node_index;
    m1_nxt.val   = in_data.node_value;
    case (in_data.opcode)
      OP_EVAL:  m1_nxt.ok = x_in;
      OP_WRITE: m1_nxt.ok = idx_in;
      OP_READ:  m1_nxt.ok = idx_in;
      default:  m1_nxt.ok = 1'b0;
    endcase
  end

  meta_t         m1_r;
  logic [31:0]   d1_r, span1_r;
  logic [AW-1:0] nm1_1_r;
  logic [KW-1:0] nm1_full;

  assign nm1_full = n_eff - KW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_r.valid <= 1'b0;
    end else begin
      m1_r <= m1_nxt;
    end
    d1_r    <= d_full[31:0];
    span1_r <= span_full[31:0];
    nm1_1_r <= nm1_full[AW-1:0];
  end

  // stage 2: scale the offset by the bin count
  meta_t       m2_r;
  logic [PW-1:0] p2_r;
  logic [31:0] span2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_r.valid <= 1'b0;
    end else begin
      m2_r <= m1_r;
    end
    p2_r    <= PW'(d1_r) * PW'(nm1_1_r);
    span2_r <= span1_r;
  end

  // divider: (p << 16) / span gives bin and fraction together
  meta_t         dm;
  logic [QW-1:0] quot;
  logic [QW-1:0] low_init;

  assign low_init = {p2_r[AW-1:0], {FRAC_BITS{1'b0}}};

  ugli_div #(.QW(QW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_meta  (m2_r),
    .in_rem   (p2_r[PW-1:AW]),
    .in_low   (low_init),
    .in_span  (span2_r),
    .out_meta (dm),
    .out_quot (quot)
  );

  // node table access, both copies written alike
  logic [AW-1:0] bin, bin_p1, idx_a, raddr0;
  logic [XW-1:0] idx_x;
  logic          we;
  logic [31:0]   rd0, rd1;

  assign bin    = quot[QW-1:FRAC_BITS];
  assign bin_p1 = bin + AW'(1);
  assign idx_x  = XW'(dm.idx);
  assign idx_a  = idx_x[AW-1:0];
  assign raddr0 = (dm.op == OP_EVAL) ? bin : idx_a;
  assign we     = dm.valid && dm.ok && (dm.op == OP_WRITE);

  ugli_ram #(.W(32), .DEPTH(NODE_COUNT)) u_ram_lo (
    .clk (clk), .we (we), .waddr (idx_a), .wdata (dm.val),
    .raddr (raddr0), .rdata (rd0)
  );

  ugli_ram #(.W(32), .DEPTH(NODE_COUNT)) u_ram_hi (
    .clk (clk), .we (we), .waddr (idx_a), .wdata (dm.val),
    .raddr (bin_p1), .rdata (rd1)
  );

  meta_t       m3_r;
  logic [15:0] frac3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_r.valid <= 1'b0;
    end else begin
      m3_r <= dm;
    end
    frac3_r <= quot[FRAC_BITS-1:0];
  end

  // stage 4: slope times fraction
  logic signed [32:0] slope;
  logic signed [16:0] frac_s;
  meta_t              m4_r;
  logic signed [31:0] lo4_r;
  logic signed [49:0] prod4_r;

  assign slope  = {rd1[31], rd1} - {rd0[31], rd0};
  assign frac_s = $signed({1'b0, frac3_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_r.valid <= 1'b0;
    end else begin
      m4_r <= m3_r;
    end
    lo4_r   <= rd0;
    prod4_r <= slope * frac_s;
  end

  // stage 5: add, saturate, select result
  logic signed [34:0] sum;
  logic signed [31:0] interp;
  out_item_t          res_nxt;

  always_comb begin
    // the shift right floors the product
    sum = 35'(lo4_r) + 35'($signed(prod4_r[49:FRAC_BITS]));
    if (sum > 35'sh0_7FFF_FFFF) begin
      interp = 32'sh7FFF_FFFF;
    end else if (sum < -35'sh0_8000_0000) begin
      interp = -32'sh8000_0000;
    end else begin
      interp = sum[31:0];
    end
    res_nxt.in_range = m4_r.ok;
    res_nxt.result_value = '0;
    if (m4_r.ok) begin
      case (m4_r.op)
        OP_EVAL: res_nxt.result_value = interp;
        OP_READ: res_nxt.result_value = lo4_r;
        default: res_nxt.result_value = '0;
      endcase
    end
  end

  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m4_r.valid;
    end
    out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
endmodule

FILE: rtl/ugli_checker.sv
// port level checks for the uniform grid interpolator, bound to the top level
// depends on ugli_pkg and uniform_grid_linear_interpolator_defines.svh
`include "uniform_grid_linear_interpolator_defines.svh"

module ugli_checker import ugli_pkg::*; #(
  parameter int NODE_COUNT = 256
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input in_item_t    in_data,
  input logic        out_valid,
  input out_item_t   out_data
);
  localparam int AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LAT = AW + 21;

  logic acc;
  logic acc_wr;
  assign acc    = start && !busy;
  assign acc_wr = acc && (in_data.opcode == OP_WRITE);

  `UGLI_NEVER(a_never_busy, clk, rst_n, busy, "busy raised")
  `UGLI_ASSERT(a_latency, clk, rst_n, acc |-> ##LAT out_valid, "result beat missing")
  `UGLI_ASSERT(a_out_of_range_zero, clk, rst_n,
    (out_valid && !out_data.in_range) |-> (out_data.result_value == 0), "nonzero miss")
  `UGLI_ASSERT(a_write_zero, clk, rst_n,
    acc_wr |-> ##LAT (out_data.result_value == 0), "write returned data")
endmodule

bind uniform_grid_linear_interpolator ugli_checker #(.NODE_COUNT(NODE_COUNT)) u_ugli_checker (.*);
